FILE: src/pf_pkg.sv
// shared types, constants and helper functions for the playfair digraph cipher
package pf_pkg;

   // key square geometry
   localparam int SQUARE_SIDE = 5;
   localparam int SQUARE_CELLS = SQUARE_SIDE * SQUARE_SIDE;
   localparam int LETTER_W = 5;
   localparam int POS_W = 3;
   localparam int SQUARE_W = SQUARE_CELLS * LETTER_W;
   localparam int CELL_IDX_W = 5;
   localparam int BIT_IDX_W = 7;

   // config register widths
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 50;
   localparam int ROW_PAIR_W = 50;
   localparam int ROW_LAST_W = 25;

   // queue depth defaults
   localparam int JOB_DEPTH_DEFAULT = 4;
   localparam int RSP_DEPTH_DEFAULT = 4;

   // letter codes
   localparam logic [LETTER_W-1:0] CODE_I = 5'd8;
   localparam logic [LETTER_W-1:0] CODE_J = 5'd9;
   localparam logic [LETTER_W-1:0] CODE_X = 5'd23;
   localparam logic [LETTER_W-1:0] CODE_Z = 5'd25;

   // config register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FIRST_TEN  = 2'd0,
      CSR_SECOND_TEN = 2'd1,
      CSR_LAST_FIVE  = 2'd2,
      CSR_DECRYPT    = 2'd3
   } csr_index_type;

   // one pair waiting to be enciphered
   typedef struct packed {
      logic [LETTER_W-1:0] first;
      logic [LETTER_W-1:0] second;
      logic                last;
   } job_type;

   // one result letter
   typedef struct packed {
      logic [LETTER_W-1:0] letter;
      logic                last;
   } rsp_type;

   // position of a letter in the square
   typedef struct packed {
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
   } pos_type;

   // clamp to z and fold j onto i
   function automatic logic [LETTER_W-1:0] fold(input logic [LETTER_W-1:0] c);
      logic [LETTER_W-1:0] v;
      v = (c > CODE_Z) ? CODE_Z : c;
      if (v == CODE_J) begin
         v = CODE_I;
      end
      return v;
   endfunction

   // first match in row-major order, row 0 column 0 when absent
   function automatic pos_type locate(input logic [SQUARE_W-1:0] sq,
                                      input logic [LETTER_W-1:0] c);
      pos_type p;
      p = '0;
      for (int r = SQUARE_SIDE - 1; r >= 0; r--) begin
         for (int k = SQUARE_SIDE - 1; k >= 0; k--) begin
            if (sq[(r * SQUARE_SIDE + k) * LETTER_W +: LETTER_W] == c) begin
               p.row = POS_W'(r);
               p.col = POS_W'(k);
            end
         end
      end
      return p;
   endfunction

   // one step along a row or column with wrap, forward or back
   function automatic logic [POS_W-1:0] shift(input logic [POS_W-1:0] v,
                                              input logic back);
      logic [POS_W-1:0] r;
      if (back) begin
         r = (v == '0) ? POS_W'(SQUARE_SIDE - 1) : v - POS_W'(1);
      end else begin
         r = (v == POS_W'(SQUARE_SIDE - 1)) ? '0 : v + POS_W'(1);
      end
      return r;
   endfunction

   // read a square entry, codes above z read as z
   function automatic logic [LETTER_W-1:0] cell_letter(input logic [SQUARE_W-1:0] sq,
                                                       input logic [POS_W-1:0] row,
                                                       input logic [POS_W-1:0] col);
      logic [CELL_IDX_W-1:0] idx;
      logic [BIT_IDX_W-1:0]  base;
      logic [LETTER_W-1:0]   v;
      idx = CELL_IDX_W'(row) * CELL_IDX_W'(SQUARE_SIDE) + CELL_IDX_W'(col);
      base = BIT_IDX_W'(idx) * BIT_IDX_W'(LETTER_W);
      v = sq[base +: LETTER_W];
      return (v > CODE_Z) ? CODE_Z : v;
   endfunction

endpackage

FILE: src/playfair_digraph_cipher_top.sv
// top level of the playfair digraph cipher: config registers, front, back and queues
//
// Takes one letter per cycle while req_full is low and gives out one letter per
// cycle while results wait and rsp_pop is high. A letter that only opens a pair
// gives nothing; a letter that closes a pair gives two, and a final letter that
// closes a split double gives four, holding req_full high while the second pair
// enters the pair queue. The back end locates both letters of a pair at once and
// writes the two result letters into the result queue one after the other, so
// the result port sets the long-run rate at one letter per cycle while rsp_pop
// stays high. The key square and mode must be written through the csr port
// while no message is in flight; the block itself does not enforce this.
module playfair_digraph_cipher_top #(
   parameter int JOB_DEPTH = pf_pkg::JOB_DEPTH_DEFAULT,
   parameter int RSP_DEPTH = pf_pkg::RSP_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic [pf_pkg::LETTER_W-1:0]      req_letter_in,
   input  logic                             req_last_in,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic [pf_pkg::LETTER_W-1:0]      rsp_letter_out,
   output logic                             rsp_last_out,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [pf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pf_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int JOB_W = $bits(pf_pkg::job_type);
   localparam int RSP_W = $bits(pf_pkg::rsp_type);

   logic [pf_pkg::ROW_PAIR_W-1:0] sq_first_ff, sq_first_in;
   logic [pf_pkg::ROW_PAIR_W-1:0] sq_second_ff, sq_second_in;
   logic [pf_pkg::ROW_LAST_W-1:0] sq_last_ff, sq_last_in;
   logic                          decrypt_ff, decrypt_in;
   logic [pf_pkg::SQUARE_W-1:0]   square;

   logic             job_push, job_full, job_pop, job_empty;
   pf_pkg::job_type  job_wr, job_rd;
   logic [JOB_W-1:0] job_rd_bits;
   logic             rsp_push, rsp_full;
   pf_pkg::rsp_type  rsp_wr, rsp_rd;
   logic [RSP_W-1:0] rsp_rd_bits;

   // config register writes
   assign csr_ready = 1'b1;
   always_comb begin
      sq_first_in = sq_first_ff;
      sq_second_in = sq_second_ff;
      sq_last_in = sq_last_ff;
      decrypt_in = decrypt_ff;
      if (csr_valid) begin
         unique case (pf_pkg::csr_index_type'(csr_index))
            pf_pkg::CSR_FIRST_TEN:  sq_first_in = csr_data;
            pf_pkg::CSR_SECOND_TEN: sq_second_in = csr_data;
            pf_pkg::CSR_LAST_FIVE:  sq_last_in = csr_data[pf_pkg::ROW_LAST_W-1:0];
            pf_pkg::CSR_DECRYPT:    decrypt_in = csr_data[0];
            default:                decrypt_in = decrypt_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_first_ff <= '0;
         sq_second_ff <= '0;
         sq_last_ff <= '0;
         decrypt_ff <= 1'b0;
      end else begin
         sq_first_ff <= sq_first_in;
         sq_second_ff <= sq_second_in;
         sq_last_ff <= sq_last_in;
         decrypt_ff <= decrypt_in;
      end
   end

   assign square = {sq_last_ff, sq_second_ff, sq_first_ff};

   // pairing front end
   pf_front u_front (
      .clock        (clock),
      .reset        (reset),
      .decrypt_mode (decrypt_ff),
      .push         (req_push),
      .letter_in    (req_letter_in),
      .last_in      (req_last_in),
      .full         (req_full),
      .job_push     (job_push),
      .job_data     (job_wr),
      .job_full     (job_full)
   );

   // pair queue between front and back
   pf_fifo #(
      .WIDTH (JOB_W),
      .DEPTH (JOB_DEPTH)
   ) u_job_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_wr),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (job_rd_bits),
      .empty     (job_empty)
   );
   assign job_rd = job_rd_bits;

   // square lookup back end
   pf_back u_back (
      .clock        (clock),
      .reset        (reset),
      .square       (square),
      .decrypt_mode (decrypt_ff),
      .job_empty    (job_empty),
      .job_data     (job_rd),
      .job_pop      (job_pop),
      .rsp_push     (rsp_push),
      .rsp_data     (rsp_wr),
      .rsp_full     (rsp_full)
   );

   // result queue
   pf_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_wr),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_rd_bits),
      .empty     (rsp_empty)
   );
   assign rsp_rd = rsp_rd_bits;
   assign rsp_letter_out = rsp_rd.letter;
   assign rsp_last_out = rsp_rd.last;

endmodule

FILE: src/pf_fifo.sv
// small register queue with push/full and pop/empty sides
module pf_fifo #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: src/pf_front.sv
// front end: folds letters, pairs them up, splits doubles when encrypting and pads the tail
module pf_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             decrypt_mode,
   input  logic                             push,
   input  logic [pf_pkg::LETTER_W-1:0]      letter_in,
   input  logic                             last_in,
   output logic                             full,
   output logic                             job_push,
   output pf_pkg::job_type                  job_data,
   input  logic                             job_full
);

   logic [pf_pkg::LETTER_W-1:0] held_letter_ff, held_letter_in;
   logic                        held_valid_ff, held_valid_in;
   logic                        pending_valid_ff, pending_valid_in;
   pf_pkg::job_type             pending_ff, pending_in;
   logic                        accept;
   logic [pf_pkg::LETTER_W-1:0] c;
   logic                        emit;
   pf_pkg::job_type             emit_job;

   // a second pair from one request blocks intake until it enters the pair queue
   assign full = pending_valid_ff || job_full;
   assign accept = push && !full;
   assign c = pf_pkg::fold(letter_in);

   // pairing decisions
   always_comb begin
      held_letter_in = held_letter_ff;
      held_valid_in = held_valid_ff;
      pending_valid_in = pending_valid_ff;
      pending_in = pending_ff;
      emit = 1'b0;
      emit_job = '{first: c, second: pf_pkg::CODE_X, last: 1'b1};
      if (pending_valid_ff && !job_full) begin
         pending_valid_in = 1'b0;
      end
      if (accept) begin
         if (!held_valid_ff) begin
            // lone final letter gets padded, otherwise it opens a pair
            if (last_in) begin
               emit = 1'b1;
               emit_job = '{first: c, second: pf_pkg::CODE_X, last: 1'b1};
            end else begin
               held_letter_in = c;
               held_valid_in = 1'b1;
            end
         end else if (!decrypt_mode && c == held_letter_ff) begin
            // doubled letter: close with x, repeat opens the next pair
            emit = 1'b1;
            emit_job = '{first: held_letter_ff, second: pf_pkg::CODE_X, last: 1'b0};
            if (last_in) begin
               pending_valid_in = 1'b1;
               pending_in = '{first: c, second: pf_pkg::CODE_X, last: 1'b1};
               held_valid_in = 1'b0;
               held_letter_in = '0;
            end else begin
               held_letter_in = c;
               held_valid_in = 1'b1;
            end
         end else begin
            emit = 1'b1;
            emit_job = '{first: held_letter_ff, second: c, last: last_in};
            held_valid_in = 1'b0;
            held_letter_in = '0;
         end
      end
   end

   assign job_push = (pending_valid_ff && !job_full) || emit;
   assign job_data = pending_valid_ff ? pending_ff : emit_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_letter_ff <= '0;
         held_valid_ff <= 1'b0;
         pending_valid_ff <= 1'b0;
      end else begin
         held_letter_ff <= held_letter_in;
         held_valid_ff <= held_valid_in;
         pending_valid_ff <= pending_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pending_ff <= pending_in;
   end

endmodule

FILE: src/pf_back.sv
// back end: locates a pair in the square, then emits the two result letters
module pf_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [pf_pkg::SQUARE_W-1:0]  square,
   input  logic                         decrypt_mode,
   input  logic                         job_empty,
   input  pf_pkg::job_type              job_data,
   output logic                         job_pop,
   output logic                         rsp_push,
   output pf_pkg::rsp_type              rsp_data,
   input  logic                         rsp_full
);

   // locate stage
   logic            s1_valid_ff, s1_valid_in;
   pf_pkg::pos_type s1_pa_ff, s1_pb_ff;
   logic            s1_last_ff;

   // emit stage
   logic                        s2_valid_ff, s2_valid_in;
   logic                        s2_phase_ff, s2_phase_in;
   logic [pf_pkg::LETTER_W-1:0] s2_first_ff, s2_second_ff;
   logic                        s2_last_ff;

   logic                        s2_free, s2_load, s1_free;
   logic [pf_pkg::POS_W-1:0]    ra, ca, rb, cb;
   logic [pf_pkg::POS_W-1:0]    ora, oca, orb, ocb;

   // stage handshakes
   assign rsp_push = s2_valid_ff && !rsp_full;
   assign s2_free = !s2_valid_ff || (s2_phase_ff && !rsp_full);
   assign s2_load = s1_valid_ff && s2_free;
   assign s1_free = !s1_valid_ff || s2_load;
   assign job_pop = !job_empty && s1_free;

   assign rsp_data = '{letter: s2_phase_ff ? s2_second_ff : s2_first_ff,
                       last: s2_phase_ff && s2_last_ff};

   // playfair rules on located positions
   assign ra = s1_pa_ff.row;
   assign ca = s1_pa_ff.col;
   assign rb = s1_pb_ff.row;
   assign cb = s1_pb_ff.col;
   always_comb begin
      ora = ra;
      orb = rb;
      oca = cb;
      ocb = ca;
      if (ra == rb) begin
         oca = pf_pkg::shift(ca, decrypt_mode);
         ocb = pf_pkg::shift(cb, decrypt_mode);
      end else if (ca == cb) begin
         ora = pf_pkg::shift(ra, decrypt_mode);
         orb = pf_pkg::shift(rb, decrypt_mode);
         oca = ca;
         ocb = cb;
      end
   end

   // valid and phase control
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s2_valid_in = s2_valid_ff;
      s2_phase_in = s2_phase_ff;
      if (job_pop) begin
         s1_valid_in = 1'b1;
      end else if (s2_load) begin
         s1_valid_in = 1'b0;
      end
      if (s2_load) begin
         s2_valid_in = 1'b1;
         s2_phase_in = 1'b0;
      end else if (rsp_push) begin
         if (s2_phase_ff) begin
            s2_valid_in = 1'b0;
         end
         s2_phase_in = !s2_phase_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s2_phase_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s2_phase_ff <= s2_phase_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (job_pop) begin
         s1_pa_ff <= pf_pkg::locate(square, job_data.first);
         s1_pb_ff <= pf_pkg::locate(square, job_data.second);
         s1_last_ff <= job_data.last;
      end
      if (s2_load) begin
         s2_first_ff <= pf_pkg::cell_letter(square, ora, oca);
         s2_second_ff <= pf_pkg::cell_letter(square, orb, ocb);
         s2_last_ff <= s1_last_ff;
      end
   end

endmodule

FILE: dv/tb_playfair_digraph_cipher_top.sv
// self-checking testbench for the playfair digraph cipher top level
module tb_playfair_digraph_cipher_top;

   localparam int STALL_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 12;
   localparam int REPORT_LIMIT = 10;
   localparam int LONG_HOLD = 120;

   localparam int LETTER_W = pf_pkg::LETTER_W;
   localparam int SQUARE_W = pf_pkg::SQUARE_W;
   localparam int SQUARE_SIDE = pf_pkg::SQUARE_SIDE;
   localparam int SQUARE_CELLS = pf_pkg::SQUARE_CELLS;
   localparam int CSR_INDEX_W = pf_pkg::CSR_INDEX_W;
   localparam int CSR_DATA_W = pf_pkg::CSR_DATA_W;
   localparam int ROW_PAIR_W = pf_pkg::ROW_PAIR_W;
   localparam int ROW_LAST_W = pf_pkg::ROW_LAST_W;

   // one letter waiting to be offered
   typedef struct packed {
      logic [LETTER_W-1:0] letter;
      logic                last;
   } plain_item_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_push = 1'b0;
   logic                   req_full;
   logic [LETTER_W-1:0]    req_letter_in = '0;
   logic                   req_last_in = 1'b0;
   logic                   rsp_empty;
   logic                   rsp_pop = 1'b0;
   logic [LETTER_W-1:0]    rsp_letter_out;
   logic                   rsp_last_out;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = pf_pkg::CSR_FIRST_TEN;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   playfair_digraph_cipher_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_letter_in  (req_letter_in),
      .req_last_in    (req_last_in),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_letter_out (rsp_letter_out),
      .rsp_last_out   (rsp_last_out),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   // clock
   initial begin
      forever #1 clock = ~clock;
   end

   // predictor copy of the key square, mode and open pair
   logic [SQUARE_W-1:0] key_square = '0;
   logic                decrypt_on = 1'b0;
   logic [LETTER_W-1:0] open_letter = '0;
   logic                open_valid = 1'b0;

   plain_item_type    plain_pending[$];
   pf_pkg::rsp_type   cipher_expected[$];
   plain_item_type    next_item;
   pf_pkg::rsp_type   want;

   int letters_queued = 0;
   int letters_accepted = 0;
   int letters_checked = 0;
   int csr_writes = 0;
   int full_stalls = 0;
   int mismatches = 0;
   int burst_left = 0;
   int gap_left = 0;
   int hold_left = 0;
   int hold_trigger = 32'h7fff_ffff;
   bit hold_done = 1'b0;
   int rx_cycle = 0;
   int idle_cycles = 0;

   // square entry k as read out, codes above z read as z
   function automatic logic [LETTER_W-1:0] square_read(input int k);
      logic [LETTER_W-1:0] v;
      v = key_square[k * LETTER_W +: LETTER_W];
      return (v > pf_pkg::CODE_Z) ? pf_pkg::CODE_Z : v;
   endfunction

   // first match in row-major order, entry 0 when missing
   function automatic int square_pos(input logic [LETTER_W-1:0] c);
      for (int k = 0; k < SQUARE_CELLS; k++) begin
         if (key_square[k * LETTER_W +: LETTER_W] == c) begin
            return k;
         end
      end
      return 0;
   endfunction

   // cipher one digraph into two expected letters
   task automatic encipher_pair(input logic [LETTER_W-1:0] a, input logic [LETTER_W-1:0] b,
                                input logic last);
      int pa, pb, ra, ca, rb, cb, step, oa, ob;
      pa = square_pos(a);
      pb = square_pos(b);
      ra = pa / SQUARE_SIDE;
      ca = pa % SQUARE_SIDE;
      rb = pb / SQUARE_SIDE;
      cb = pb % SQUARE_SIDE;
      step = decrypt_on ? SQUARE_SIDE - 1 : 1;
      if (ra == rb) begin
         oa = ra * SQUARE_SIDE + (ca + step) % SQUARE_SIDE;
         ob = rb * SQUARE_SIDE + (cb + step) % SQUARE_SIDE;
      end else if (ca == cb) begin
         oa = ((ra + step) % SQUARE_SIDE) * SQUARE_SIDE + ca;
         ob = ((rb + step) % SQUARE_SIDE) * SQUARE_SIDE + cb;
      end else begin
         oa = ra * SQUARE_SIDE + cb;
         ob = rb * SQUARE_SIDE + ca;
      end
      cipher_expected.push_back('{letter: square_read(oa), last: 1'b0});
      cipher_expected.push_back('{letter: square_read(ob), last: last});
   endtask

   // pair up an accepted letter, splitting doubles when encrypting
   task automatic take_plain_letter(input logic [LETTER_W-1:0] raw, input logic last);
      logic [LETTER_W-1:0] c;
      c = (raw > pf_pkg::CODE_Z) ? pf_pkg::CODE_Z : raw;
      if (c == pf_pkg::CODE_J) begin
         c = pf_pkg::CODE_I;
      end
      if (!open_valid) begin
         if (last) begin
            encipher_pair(c, pf_pkg::CODE_X, 1'b1);
         end else begin
            open_letter = c;
            open_valid = 1'b1;
         end
      end else if (!decrypt_on && c == open_letter) begin
         encipher_pair(open_letter, pf_pkg::CODE_X, 1'b0);
         if (last) begin
            encipher_pair(c, pf_pkg::CODE_X, 1'b1);
            open_valid = 1'b0;
            open_letter = '0;
         end else begin
            open_letter = c;
         end
      end else begin
         encipher_pair(open_letter, c, last);
         open_valid = 1'b0;
         open_letter = '0;
      end
   endtask

   // compare one popped letter with the oldest expectation
   task automatic check_cipher_letter();
      if (cipher_expected.size() == 0) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT) begin
            $display("unexpected letter %0d last %0d with nothing pending",
                     rsp_letter_out, rsp_last_out);
         end
      end else begin
         want = cipher_expected.pop_front();
         if (want.letter !== rsp_letter_out || want.last !== rsp_last_out) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("letter %0d: expected %0d last %0d, got %0d last %0d",
                        letters_checked, want.letter, want.last, rsp_letter_out,
                        rsp_last_out);
            end
         end
      end
      letters_checked++;
   endtask

   // request driver: bursts of letters with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         req_letter_in <= '0;
         req_last_in <= 1'b0;
         burst_left = $urandom_range(1, 32);
         gap_left = 0;
      end else begin
         if (req_push && !req_full) begin
            take_plain_letter(req_letter_in, req_last_in);
            letters_accepted++;
         end
         if (req_push && req_full) begin
            full_stalls++;
         end else if (gap_left > 0) begin
            gap_left--;
            req_push <= 1'b0;
         end else if (plain_pending.size() > 0) begin
            next_item = plain_pending.pop_front();
            req_push <= 1'b1;
            req_letter_in <= next_item.letter;
            req_last_in <= next_item.last;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 32);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // result monitor: checks pops and stalls on its own pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            check_cipher_letter();
         end
         rx_cycle++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (!hold_done && letters_accepted >= hold_trigger) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            rsp_pop <= 1'b0;
         end else begin
            case (rx_cycle[8:6])
               3'd0, 3'd1: begin
                  rsp_pop <= 1'b1;
               end
               3'd2: begin
                  rsp_pop <= 1'($urandom_range(0, 1));
               end
               3'd3: begin
                  rsp_pop <= (rx_cycle[1:0] == 2'd0);
               end
               3'd4: begin
                  rsp_pop <= (rx_cycle[1:0] != 2'd3);
               end
               default: begin
                  rsp_pop <= ($urandom_range(0, 7) != 0);
               end
            endcase
         end
      end
   end

   // watchdog on cycles with no handshake anywhere
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)
          || (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", idle_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   function automatic logic [LETTER_W-1:0] letter_of(input byte ch);
      return LETTER_W'(ch - 8'd97);
   endfunction

   task automatic queue_letter(input logic [LETTER_W-1:0] c, input logic last);
      plain_pending.push_back('{letter: c, last: last});
      letters_queued++;
   endtask

   // wait until every letter is in and every result is out, then let the block settle
   task automatic drain();
      while (letters_accepted != letters_queued || cipher_expected.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one register write over the csr channel, mirrored into the predictor
   task automatic csr_write(input pf_pkg::csr_index_type idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         pf_pkg::CSR_FIRST_TEN:  key_square[ROW_PAIR_W-1:0] = data;
         pf_pkg::CSR_SECOND_TEN: key_square[2*ROW_PAIR_W-1:ROW_PAIR_W] = data;
         pf_pkg::CSR_LAST_FIVE:  key_square[SQUARE_W-1:2*ROW_PAIR_W] = data[ROW_LAST_W-1:0];
         pf_pkg::CSR_DECRYPT:    decrypt_on = data[0];
         default: ;
      endcase
      csr_writes++;
   endtask

   // load a whole square and mode, with junk above the used bits
   task automatic apply_settings(input logic [SQUARE_W-1:0] sq, input logic mode);
      csr_write(pf_pkg::CSR_FIRST_TEN, sq[ROW_PAIR_W-1:0]);
      csr_write(pf_pkg::CSR_SECOND_TEN, sq[2*ROW_PAIR_W-1:ROW_PAIR_W]);
      csr_write(pf_pkg::CSR_LAST_FIVE, {25'($urandom), sq[SQUARE_W-1:2*ROW_PAIR_W]});
      csr_write(pf_pkg::CSR_DECRYPT, {49'({$urandom, $urandom}), mode});
   endtask

   // a..z without j in order
   function automatic logic [SQUARE_W-1:0] alphabet_square();
      logic [SQUARE_W-1:0] sq;
      int k;
      sq = '0;
      k = 0;
      for (int c = 0; c <= pf_pkg::CODE_Z; c++) begin
         if (c != pf_pkg::CODE_J) begin
            sq[k * LETTER_W +: LETTER_W] = LETTER_W'(c);
            k++;
         end
      end
      return sq;
   endfunction

   // a well-formed key square in random order
   function automatic logic [SQUARE_W-1:0] shuffled_square();
      logic [SQUARE_W-1:0] sq;
      logic [LETTER_W-1:0] tmp;
      int j;
      sq = alphabet_square();
      for (int k = SQUARE_CELLS - 1; k > 0; k--) begin
         j = $urandom_range(0, k);
         tmp = sq[k * LETTER_W +: LETTER_W];
         sq[k * LETTER_W +: LETTER_W] = sq[j * LETTER_W +: LETTER_W];
         sq[j * LETTER_W +: LETTER_W] = tmp;
      end
      return sq;
   endfunction

   // few distinct codes, so repeats and missing letters are common
   function automatic logic [SQUARE_W-1:0] narrow_square();
      logic [SQUARE_W-1:0] sq;
      for (int k = 0; k < SQUARE_CELLS; k++) begin
         sq[k * LETTER_W +: LETTER_W] = LETTER_W'($urandom_range(0, 7));
      end
      return sq;
   endfunction

   // random messages with doubles, j, and codes past z
   task automatic queue_random_text(input int count);
      int msg_left;
      int roll;
      logic [LETTER_W-1:0] c;
      logic [LETTER_W-1:0] prev;
      logic last;
      msg_left = $urandom_range(1, 12);
      prev = '0;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 20 && n > 0) begin
            c = prev;
         end else if (roll < 26) begin
            c = LETTER_W'($urandom_range(pf_pkg::CODE_Z + 1, 31));
         end else if (roll < 34) begin
            c = pf_pkg::CODE_J;
         end else begin
            c = LETTER_W'($urandom_range(0, pf_pkg::CODE_Z));
         end
         msg_left--;
         last = (msg_left == 0) || (n == count - 1);
         queue_letter(c, last);
         if (last) begin
            msg_left = $urandom_range(1, 12);
         end
         prev = c;
      end
   endtask

   // stimulus and end of run
   initial begin
      logic [127:0] raw;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // square still at reset: nothing found, everything lands on entry 0
      queue_letter(letter_of("h"), 1'b1);
      drain();

      // plain alphabet square, encrypt
      apply_settings(alphabet_square(), 1'b0);
      queue_letter(letter_of("a"), 1'b0);
      queue_letter(letter_of("b"), 1'b1);
      queue_letter(letter_of("a"), 1'b0);
      queue_letter(letter_of("f"), 1'b1);
      // doubled letter split then closed
      queue_letter(letter_of("l"), 1'b0);
      queue_letter(letter_of("l"), 1'b0);
      queue_letter(letter_of("o"), 1'b1);
      // doubled final letter: split pair plus padded pair
      queue_letter(letter_of("e"), 1'b0);
      queue_letter(letter_of("e"), 1'b1);
      // j folds onto i and doubles
      queue_letter(pf_pkg::CODE_J, 1'b0);
      queue_letter(pf_pkg::CODE_I, 1'b0);
      queue_letter(letter_of("k"), 1'b1);
      // code past z doubles with z
      queue_letter(pf_pkg::CODE_Z, 1'b0);
      queue_letter(5'd31, 1'b1);
      // lone x padded with x
      queue_letter(pf_pkg::CODE_X, 1'b1);
      // left open across the mode change
      queue_letter(letter_of("m"), 1'b0);
      drain();
      csr_write(pf_pkg::CSR_DECRYPT, 50'd1);

      // decrypt, finishing the held pair first
      queue_letter(letter_of("g"), 1'b1);
      queue_letter(letter_of("y"), 1'b0);
      queue_letter(letter_of("y"), 1'b1);
      queue_letter(letter_of("d"), 1'b0);
      queue_letter(letter_of("u"), 1'b1);
      queue_letter(letter_of("q"), 1'b0);
      queue_letter(letter_of("v"), 1'b1);
      queue_letter(letter_of("s"), 1'b1);
      drain();

      // random messages under several settings
      apply_settings(shuffled_square(), 1'b0);
      queue_random_text(90);
      drain();

      apply_settings(shuffled_square(), 1'b1);
      hold_trigger = letters_accepted + 20;
      queue_random_text(70);
      drain();

      apply_settings('1, 1'b0);
      queue_random_text(15);
      drain();

      raw = {$urandom, $urandom, $urandom, $urandom};
      apply_settings({{ROW_LAST_W{1'b1}}, {ROW_PAIR_W{1'b0}}, raw[ROW_PAIR_W-1:0]}, 1'b1);
      queue_random_text(25);
      drain();

      apply_settings(narrow_square(), 1'b0);
      queue_random_text(40);
      drain();

      apply_settings(shuffled_square(), 1'b0);
      queue_random_text(45);
      drain();

      $display("run covered %0d letters in, %0d letters out, %0d register writes",
               letters_accepted, letters_checked, csr_writes);
      $display("input held full for %0d cycles, long output hold %s",
               full_stalls, hold_done ? "done" : "not reached");
      if (mismatches == 0 && cipher_expected.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches, %0d letters still expected", mismatches,
                  cipher_expected.size());
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: files.f
src/pf_pkg.sv
src/pf_fifo.sv
src/pf_front.sv
src/pf_back.sv
src/playfair_digraph_cipher_top.sv
dv/tb_playfair_digraph_cipher_top.sv
